FILE: rtl/core/sbfr_pkg.sv
// Shared types and constants for the SBUS frame receiver.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package sbfr_pkg;

  // Frame layout: header at position 0, payload at 1..22, flags at 23, footer at 24.
  localparam int unsigned PayloadBytes = 22;
  localparam int unsigned PayloadW     = PayloadBytes * 8;
  localparam int unsigned FlagsPos     = 23;
  localparam int unsigned FooterPos    = 24;
  localparam int unsigned PosW         = 5;

  // Result field widths.
  localparam int unsigned ChanW   = 11;
  localparam int unsigned IndexW  = 4;

  // Configuration port.
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned CfgDataW   = 8;
  localparam logic [7:0]  HeaderReset = 8'h0F;
  localparam logic [7:0]  FooterReset = 8'h00;

  // Defaults for top-level parameters.
  localparam int unsigned DefaultChannels = 16;
  localparam int unsigned CmdDepth        = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_HEADER = 1'b0,
    REG_FOOTER = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FR_HUNT    = 1'b0,
    FR_ALIGNED = 1'b1
  } front_state_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_e;

  // One finished frame, or one error, handed from the front to the back.
  typedef struct packed {
    logic                is_error;
    logic [PayloadW-1:0] payload;
  } cmd_t;

endpackage

FILE: rtl/core/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver: front end, command queue and back end.
// Depends on sbfr_pkg, sbfr_front, sbfr_cmd_fifo and sbfr_back.
//
// Usage: received serial bytes are written in through push_i/full_o with
// rx_byte_i; a transaction happens when push_i is high and full_o is low.
// Decoded channels are read out through empty_o/pop_i; the oldest result is
// on the result ports while empty_o is low and is taken when pop_i is high.
// A footer byte queues one frame transaction; the back end then emits one
// channel per cycle while pop_i is held, through the single shift-and-extract
// unit. An error result passes through the command queue and the result
// register. full_o rises only when the command queue holds CmdDepth pending
// frames or errors. When the reader stalls, the result register holds and the
// back end waits; the front keeps taking bytes until the queue fills. Reset
// returns to hunting for a header, clears the command queue and the result
// register and loads the header and footer registers with their defaults.
// The configuration registers are written through cfg_we_i, cfg_addr_i and
// cfg_wdata_i; the user must write them only while the block is idle, which the
// block itself does not enforce.
`timescale 1ns / 1ps

module sbus_frame_receiver #(
  parameter int unsigned Channels = sbfr_pkg::DefaultChannels,
  parameter int unsigned CmdDepth = sbfr_pkg::CmdDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [sbfr_pkg::IndexW-1:0]   channel_index_o,
  output logic [sbfr_pkg::ChanW-1:0]    channel_value_o,
  output logic                          frame_error_o,
  output logic                          last_of_frame_o,
  input  logic                          cfg_we_i,
  input  logic [sbfr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sbfr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sbfr_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;

  sbfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  sbfr_cmd_fifo #(
    .Depth(CmdDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (back_cmd)
  );

  sbfr_back #(
    .Channels(Channels)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (back_cmd),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .frame_error_o  (frame_error_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

FILE: rtl/core/sbfr_front.sv
// Front end of the SBUS frame receiver: configuration registers, frame
// alignment and payload capture. Depends on sbfr_pkg.
`timescale 1ns / 1ps

module sbfr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [sbfr_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sbfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output sbfr_pkg::cmd_t                cmd_o
);
  import sbfr_pkg::*;

  front_state_e        state_q, state_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [7:0]          header_q, footer_q;
  logic [PayloadW-1:0] payload_q;
  logic                accept;
  logic                hit_header;
  logic                hit_footer;
  logic                shift_en;

  // A byte is taken only when the command queue has room.
  assign full_o     = cmd_full_i;
  assign accept     = push_i && !cmd_full_i;
  assign hit_header = (rx_byte_i == header_q);
  assign hit_footer = (rx_byte_i == footer_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      footer_q <= FooterReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_HEADER: header_q <= cfg_wdata_i;
        REG_FOOTER: footer_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state and frame position.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    if (accept) begin
      unique case (state_q)
        FR_HUNT: begin
          if (hit_header) begin
            state_d = FR_ALIGNED;
            pos_d   = PosW'(1);
          end
        end
        FR_ALIGNED: begin
          priority if (pos_q == '0) begin
            if (hit_header) begin
              pos_d = PosW'(1);
            end else begin
              state_d = FR_HUNT;
            end
          end else if (pos_q <= PosW'(FlagsPos)) begin
            pos_d = pos_q + PosW'(1);
          end else begin
            pos_d = '0;
            if (!hit_footer) begin
              state_d = FR_HUNT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Command generation and payload capture strobes.
  always_comb begin
    cmd_push_o     = 1'b0;
    cmd_o.is_error = 1'b1;
    cmd_o.payload  = payload_q;
    shift_en       = 1'b0;
    if (accept && state_q == FR_ALIGNED) begin
      priority if (pos_q == '0) begin
        cmd_push_o = !hit_header;
      end else if (pos_q <= PosW'(PayloadBytes)) begin
        shift_en = 1'b1;
      end else if (pos_q >= PosW'(FooterPos)) begin
        cmd_push_o     = 1'b1;
        cmd_o.is_error = !hit_footer;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_HUNT;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // Payload bytes shift in from the top, so byte 1 ends up in the low bits.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      payload_q <= {rx_byte_i, payload_q[PayloadW-1:8]};
    end
  end

  // The position is held at zero while hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_HUNT) |-> (pos_q == '0))
    else $error("sbfr_front: nonzero position while hunting");

  // The position never runs past the footer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FooterPos))
    else $error("sbfr_front: position beyond footer");

endmodule

FILE: rtl/core/sbfr_cmd_fifo.sv
// Short command queue between the front and back of the SBUS frame receiver.
// Depends on sbfr_pkg for the command type.
`timescale 1ns / 1ps

module sbfr_cmd_fifo #(
  parameter int unsigned Depth = sbfr_pkg::CmdDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbfr_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sbfr_pkg::cmd_t data_o
);
  import sbfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("sbfr_cmd_fifo: overfilled");

endmodule

FILE: rtl/core/sbfr_back.sv
// Back end of the SBUS frame receiver: unpacks 11-bit channels from a
// captured payload and holds the result register. Depends on sbfr_pkg.
`timescale 1ns / 1ps

module sbfr_back #(
  parameter int unsigned Channels = sbfr_pkg::DefaultChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_empty_i,
  input  sbfr_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [sbfr_pkg::IndexW-1:0] channel_index_o,
  output logic [sbfr_pkg::ChanW-1:0]  channel_value_o,
  output logic                        frame_error_o,
  output logic                        last_of_frame_o
);
  import sbfr_pkg::*;

  localparam int unsigned ChW = $clog2(Channels);

  back_state_e         state_q, state_d;
  logic [PayloadW-1:0] shift_q;
  logic [ChW-1:0]      cnt_q;
  logic                out_valid_q;
  logic [IndexW-1:0]   index_q;
  logic [ChanW-1:0]    value_q;
  logic                error_q;
  logic                last_q;
  logic                out_free;
  logic                is_last;
  logic                load_frame;
  logic                load_error;
  logic                emit;

  // The result register can take a new transaction when empty or being drained.
  assign out_free = !out_valid_q || pop_i;
  assign is_last  = (cnt_q == ChW'(Channels - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && out_free && !cmd_i.is_error) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && is_last) begin
          state_d = BK_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Control strobes.
  always_comb begin
    cmd_pop_o  = (state_q == BK_IDLE) && !cmd_empty_i && out_free;
    load_frame = cmd_pop_o && !cmd_i.is_error;
    load_error = cmd_pop_o && cmd_i.is_error;
    emit       = (state_q == BK_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_frame) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + ChW'(1);
      end
    end
  end

  // Channel c sits in the low 11 bits after c shifts.
  always_ff @(posedge clk_i) begin
    if (load_frame) begin
      shift_q <= cmd_i.payload;
    end else if (emit) begin
      shift_q <= shift_q >> ChanW;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_error || emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_error) begin
      index_q <= '0;
      value_q <= '0;
      error_q <= 1'b1;
      last_q  <= 1'b1;
    end else if (emit) begin
      index_q <= IndexW'(cnt_q);
      value_q <= shift_q[ChanW-1:0];
      error_q <= 1'b0;
      last_q  <= is_last;
    end
  end

  assign empty_o         = !out_valid_q;
  assign channel_index_o = index_q;
  assign channel_value_o = value_q;
  assign frame_error_o   = error_q;
  assign last_of_frame_o = last_q;

  // An error result carries zero fields and closes its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q) |-> (last_q && index_q == '0 && value_q == '0))
    else $error("sbfr_back: malformed error result");

  // The closing result of a good frame is the highest channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !error_q && last_q) |-> (index_q == IndexW'(Channels - 1)))
    else $error("sbfr_back: frame closed on wrong channel");

  // A stalled result register freezes channel progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT && out_valid_q && !pop_i) |=> $stable(cnt_q))
    else $error("sbfr_back: channel skipped under stall");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for sbus_frame_receiver: byte stream in, decoded channels out.
// Depends on sbfr_pkg and the RTL under rtl/core; has its own frame decoder for predictions.
`timescale 1ns / 1ps

module tb;
  import sbfr_pkg::*;

  localparam int unsigned NumChannels  = DefaultChannels;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 1500;
  localparam int unsigned PressFrames  = 3;

  // Expected result written straight into a directed row, where it is obvious.
  typedef enum logic [1:0] {
    GOLD_NONE,
    GOLD_ERROR,
    GOLD_ALL_ZERO,
    GOLD_ALL_ONES
  } golden_e;

  typedef struct packed {
    logic [7:0] rx;
    golden_e    gold;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] rx;
    logic [4:0] reps;
    golden_e    gold;
  } script_row_t;

  typedef struct packed {
    logic [IndexW-1:0] ch_index;
    logic [ChanW-1:0]  ch_value;
    logic              frame_err;
    logic              frame_last;
  } chan_result_t;

  // Directed frames under the reset header (0x0F) and footer (0x00).
  localparam script_row_t Script [0:10] = '{
    '{8'h00, 5'd1,  GOLD_NONE},      // dropped while hunting
    '{8'hFF, 5'd1,  GOLD_NONE},      // dropped while hunting
    '{8'h0F, 5'd1,  GOLD_NONE},      // header
    '{8'hFF, 5'd22, GOLD_NONE},      // payload all ones
    '{8'h5A, 5'd1,  GOLD_NONE},      // flags, ignored
    '{8'h00, 5'd1,  GOLD_ALL_ONES},  // good footer
    '{8'h3C, 5'd1,  GOLD_ERROR},     // wrong byte where a header is due
    '{8'h0F, 5'd1,  GOLD_NONE},      // header ends hunting
    '{8'hA5, 5'd22, GOLD_NONE},
    '{8'h0F, 5'd1,  GOLD_NONE},      // flags equal to the header value
    '{8'h01, 5'd1,  GOLD_ERROR}      // bad footer
  };

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                push_i      = 1'b0;
  logic                full_o;
  logic [7:0]          rx_byte_i   = 8'h00;
  logic                empty_o;
  logic                pop_i       = 1'b0;
  logic [IndexW-1:0]   channel_index_o;
  logic [ChanW-1:0]    channel_value_o;
  logic                frame_error_o;
  logic                last_of_frame_o;
  logic                cfg_we_i    = 1'b0;
  cfg_reg_e            cfg_addr_i  = REG_HEADER;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Decoder state kept alongside the block.
  front_state_e  model_front  = FR_HUNT;
  logic [PosW-1:0] model_pos  = '0;
  logic [7:0]    model_payload [PayloadBytes];
  logic [7:0]    model_header = HeaderReset;
  logic [7:0]    model_footer = FooterReset;

  rx_item_t      byte_q [$];
  chan_result_t  pending_channels [$];
  int unsigned   errors_seen = 0;

  // Sender burst control and receiver stall control.
  int unsigned   burst_left  = 1;
  int unsigned   gap_left    = 0;
  logic          byte_taken;
  logic          hold_go     = 1'b0;
  int unsigned   hold_left   = 0;
  logic [7:0]    pop_pattern = 8'hFF;
  int unsigned   pattern_age = 0;

  sbus_frame_receiver #(
    .Channels(NumChannels)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .rx_byte_i      (rx_byte_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .frame_error_o  (frame_error_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Advance the frame decoder by one accepted byte and queue the channels it yields.
  function automatic void decode_byte(input rx_item_t item);
    chan_result_t            frame_out [$];
    logic [PayloadW-1:0]     payload_bits;
    chan_result_t            res;
    if (model_front == FR_HUNT) begin
      if (item.rx == model_header) begin
        model_front = FR_ALIGNED;
        model_pos   = PosW'(1);
      end
    end else if (model_pos == '0) begin
      if (item.rx != model_header) begin
        frame_out.push_back('{ch_index: '0, ch_value: '0, frame_err: 1'b1, frame_last: 1'b1});
        model_front = FR_HUNT;
      end else begin
        model_pos = PosW'(1);
      end
    end else if (model_pos <= PayloadBytes) begin
      model_payload[model_pos - PosW'(1)] = item.rx;
      model_pos = model_pos + PosW'(1);
    end else if (model_pos == FlagsPos) begin
      model_pos = model_pos + PosW'(1);
    end else begin
      if (item.rx != model_footer) begin
        frame_out.push_back('{ch_index: '0, ch_value: '0, frame_err: 1'b1, frame_last: 1'b1});
        model_front = FR_HUNT;
      end else begin
        // Channels are packed little-endian, 11 bits each.
        for (int i = 0; i < PayloadBytes; i++) payload_bits[8*i +: 8] = model_payload[i];
        for (int c = 0; c < NumChannels; c++) begin
          res.ch_index   = c[IndexW-1:0];
          res.ch_value   = payload_bits[11*c +: 11];
          res.frame_err  = 1'b0;
          res.frame_last = (c == NumChannels - 1);
          frame_out.push_back(res);
        end
      end
      model_pos = '0;
    end

    // Directed rows with a written-in expectation override the prediction.
    unique case (item.gold)
      GOLD_NONE: begin
        foreach (frame_out[k]) pending_channels.push_back(frame_out[k]);
      end
      GOLD_ERROR: begin
        pending_channels.push_back('{ch_index: '0, ch_value: '0, frame_err: 1'b1,
                                     frame_last: 1'b1});
      end
      default: begin
        for (int c = 0; c < NumChannels; c++) begin
          res.ch_index   = c[IndexW-1:0];
          res.ch_value   = (item.gold == GOLD_ALL_ONES) ? 11'h7FF : 11'h000;
          res.frame_err  = 1'b0;
          res.frame_last = (c == NumChannels - 1);
          pending_channels.push_back(res);
        end
      end
    endcase
  endfunction

  // Compare one popped channel transaction with the oldest expectation.
  task automatic check_channel();
    chan_result_t want;
    if (pending_channels.size() == 0) begin
      $error("unexpected result: index %0d value %0d error %0b last %0b",
             channel_index_o, channel_value_o, frame_error_o, last_of_frame_o);
      errors_seen++;
    end else begin
      want = pending_channels.pop_front();
      if (channel_index_o !== want.ch_index) begin
        $error("channel_index: expected %0d, got %0d", want.ch_index, channel_index_o);
        errors_seen++;
      end
      if (channel_value_o !== want.ch_value) begin
        $error("channel_value: expected %0d, got %0d", want.ch_value, channel_value_o);
        errors_seen++;
      end
      if (frame_error_o !== want.frame_err) begin
        $error("frame_error: expected %0b, got %0b", want.frame_err, frame_error_o);
        errors_seen++;
      end
      if (last_of_frame_o !== want.frame_last) begin
        $error("last_of_frame: expected %0b, got %0b", want.frame_last, last_of_frame_o);
        errors_seen++;
      end
    end
  endtask

  // Byte sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken = push_i && !full_o;
      if (byte_taken) decode_byte(byte_q.pop_front());
      if (push_i && !byte_taken) begin
        // Offer stays up until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        push_i <= 1'b0;
      end else if (byte_q.size() > 0) begin
        push_i    <= 1'b1;
        rx_byte_i <= byte_q[0].rx;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // Channel reader: a rotating stall pattern, plus one long hold on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) check_channel();
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = 32;
          if ($urandom_range(0, 3) == 0) pop_pattern = 8'hFF;
          else pop_pattern = 8'($urandom_range(0, 255)) | 8'h01;
        end
        pattern_age--;
        pop_i       <= pop_pattern[0];
        pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
      end
    end
  end

  function automatic void queue_rx(input logic [7:0] b);
    byte_q.push_back('{rx: b, gold: GOLD_NONE});
  endfunction

  // One frame with random content; sometimes a stray byte first or a bad footer.
  task automatic queue_frame();
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) begin
      b = 8'($urandom_range(0, 255));
      queue_rx(b);
    end
    queue_rx(model_header);
    for (int i = 0; i < PayloadBytes; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      queue_rx(b);
    end
    b = 8'($urandom_range(0, 255));
    queue_rx(b);
    if ($urandom_range(0, 7) == 0) begin
      b = 8'($urandom_range(1, 255));
      queue_rx(model_footer ^ b);
    end else begin
      queue_rx(model_footer);
    end
  endtask

  // Wait until every byte is taken and every channel has come out, then settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || push_i || pending_channels.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both registers, written back to back while the block is idle.
  task automatic write_regs(input logic [7:0] hdr, input logic [7:0] ftr);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_HEADER;
    cfg_wdata_i <= hdr;
    model_header = hdr;
    @(posedge clk_i);
    cfg_addr_i  <= REG_FOOTER;
    cfg_wdata_i <= ftr;
    model_footer = ftr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0]  hdr;
    logic [7:0]  ftr;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset register values.
    @(negedge clk_i);
    foreach (Script[i]) begin
      for (int r = 0; r < Script[i].reps; r++) begin
        byte_q.push_back('{rx: Script[i].rx, gold: Script[i].gold});
      end
    end
    wait_drained();

    // Random frames under new register values while the reader holds off, so the
    // command queue fills up; one more header byte keeps pressing on the input.
    hdr = 8'($urandom_range(0, 255));
    ftr = 8'($urandom_range(0, 255));
    write_regs(hdr, ftr);
    @(negedge clk_i);
    hold_go = 1'b1;
    for (int f = 0; f < PressFrames; f++) queue_frame();
    queue_rx(model_header);
    wait_drained();

    if (errors_seen == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
